[rtl/ybd_pkg.sv]
// ybd_pkg: beat types, register indexes and shared widths for the YOLO box decode unit.
// No dependencies; used by the sigmoid ROM and the top level.
`default_nettype none

package ybd_pkg;

  // sigmoid value, unsigned Q1.16, range 0..65536
  localparam int unsigned SIG_W = 17;

  // register index, byte address is 4*index
  localparam logic [1:0] REG_CENTER_SCALE = 2'd0;
  localparam logic [1:0] REG_CELL_STRIDE  = 2'd1;
  localparam logic [1:0] REG_SIZE_SCALE   = 2'd2;

  typedef struct packed {
    logic signed [15:0] logit;
    logic        [7:0]  attr_index;
    logic signed [15:0] cell_coord;
    logic        [15:0] anchor_size;
  } in_beat_t;

  typedef struct packed {
    logic signed [31:0] decoded_value;
    logic        [7:0]  attr_echo;
  } out_beat_t;

endpackage

`default_nettype wire

[rtl/ybd_stream_if.sv]
// ybd_stream_if: valid/ready stream channel carrying one beat of type beat_t.
// Depends on nothing; beat types come from ybd_pkg at the instantiation site.
`default_nettype none

interface ybd_stream_if #(
  parameter type beat_t = logic
);
  logic  valid;
  logic  ready;
  beat_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

[rtl/yolo_box_decode_unit.sv]
// yolo_box_decode_unit: pipelined YOLO box decode (table sigmoid, center/size/pass paths).
// Depends on ybd_pkg, ybd_stream_if and ybd_sig_rom.
//
//   port    dir   kind          beat
//   in_i    in    stream sink   logit, attr_index, cell_coord, anchor_size
//   out_o   out   stream source decoded_value, attr_echo
//   apb     in    APB slave     center_scale @0x0, cell_stride @0x4, size_scale @0x8
//
// One beat per cycle sustained while the output is not stalled; eight register stages.
// Depth is set by the mul/add chain: bin index, ROM read, scale mul, grid add / size round,
// stride or t*t mul, anchor mul, round, saturate.
// Reset clears the stage valid bits and loads the register defaults; ROM needs no fill.
// Each stage stalls on its own, so bubbles close up and a held beat is never lost.
`default_nettype none

module yolo_box_decode_unit #(
  parameter int unsigned SIGMOID_TABLE_DEPTH = 1024
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  ybd_stream_if.sink       in_i,
  ybd_stream_if.source     out_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  localparam int unsigned AW   = $clog2(SIGMOID_TABLE_DEPTH);
  localparam int unsigned NSTG = 8;

  typedef enum logic [1:0] {
    MODE_CENTER,
    MODE_SIZE,
    MODE_PASS
  } mode_e;

  // ---------------- config registers ----------------
  logic [15:0] center_scale_q;
  logic [15:0] cell_stride_q;
  logic [15:0] size_scale_q;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_scale_q <= 16'd8192;
      cell_stride_q  <= 16'd2048;
      size_scale_q   <= 16'd8192;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        ybd_pkg::REG_CENTER_SCALE: center_scale_q <= pwdata[15:0];
        ybd_pkg::REG_CELL_STRIDE:  cell_stride_q  <= pwdata[15:0];
        ybd_pkg::REG_SIZE_SCALE:   size_scale_q   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      ybd_pkg::REG_CENTER_SCALE: prdata = {16'd0, center_scale_q};
      ybd_pkg::REG_CELL_STRIDE:  prdata = {16'd0, cell_stride_q};
      ybd_pkg::REG_SIZE_SCALE:   prdata = {16'd0, size_scale_q};
      default:                   prdata = '0;
    endcase
  end

  // ---------------- stage handshake ----------------
  logic [NSTG-1:0] v_q;
  logic [NSTG-1:0] en;

  always_comb begin
    en[NSTG-1] = !v_q[NSTG-1] || out_o.ready;
    for (int k = int'(NSTG) - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign in_i.ready = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= in_i.valid;
      end
      for (int k = 1; k < int'(NSTG); k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  // side-band carried along the stages
  mode_e              mode_q   [5];
  logic [7:0]         attr_q   [NSTG];
  logic signed [15:0] grid_q   [3];
  logic [15:0]        anchor_q [5];

  // ---------------- stage 0: bin index ----------------
  logic [15:0]   biased;
  logic [32:0]   idx_prod;
  logic [AW-1:0] idx_q;
  mode_e         mode_d;

  assign biased   = {~in_i.data.logit[15], in_i.data.logit[14:0]};
  assign idx_prod = 33'(biased) * 33'(SIGMOID_TABLE_DEPTH);

  always_comb begin
    if (in_i.data.attr_index < 8'd2) begin
      mode_d = MODE_CENTER;
    end else if (in_i.data.attr_index < 8'd4) begin
      mode_d = MODE_SIZE;
    end else begin
      mode_d = MODE_PASS;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      idx_q <= idx_prod[16 +: AW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      mode_q[0]   <= mode_d;
      attr_q[0]   <= in_i.data.attr_index;
      grid_q[0]   <= in_i.data.cell_coord;
      anchor_q[0] <= in_i.data.anchor_size;
    end
    for (int k = 1; k < 5; k++) begin
      if (en[k]) begin
        mode_q[k] <= mode_q[k-1];
      end
    end
    for (int k = 1; k < int'(NSTG); k++) begin
      if (en[k]) begin
        attr_q[k] <= attr_q[k-1];
      end
    end
    for (int k = 1; k < 3; k++) begin
      if (en[k]) begin
        grid_q[k] <= grid_q[k-1];
      end
    end
    for (int k = 1; k < 5; k++) begin
      if (en[k]) begin
        anchor_q[k] <= anchor_q[k-1];
      end
    end
  end

  // ---------------- stage 1: sigmoid ROM ----------------
  logic [ybd_pkg::SIG_W-1:0] sig_q;

  ybd_sig_rom #(
    .SIGMOID_TABLE_DEPTH(SIGMOID_TABLE_DEPTH)
  ) u_sig_rom (
    .clk_i  (clk_i),
    .en_i   (en[1]),
    .addr_i (idx_q),
    .data_o (sig_q)
  );

  // ---------------- stage 2: scale multiply ----------------
  logic [15:0] scale_sel;
  logic [32:0] p_d;
  logic [32:0] p_q;

  always_comb begin
    scale_sel = (mode_q[1] == MODE_CENTER) ? center_scale_q : size_scale_q;
    if (mode_q[1] == MODE_PASS) begin
      p_d = 33'((sig_q + 17'd8) >> 4);
    end else begin
      p_d = 33'(sig_q) * 33'(scale_sel);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      p_q <= p_d;
    end
  end

  // ---------------- stage 3: grid add / size round ----------------
  logic [32:0]        t_full;
  logic signed [40:0] a_d;
  logic signed [40:0] a_q;

  assign t_full = (p_q + 33'd2048) >> 12;

  always_comb begin
    case (mode_q[2])
      MODE_CENTER: a_d = $signed({8'd0, p_q}) + (41'(grid_q[2]) <<< 24);
      MODE_SIZE:   a_d = $signed({20'd0, t_full[20:0]});
      default:     a_d = $signed({8'd0, p_q});
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      a_q <= a_d;
    end
  end

  // ---------------- stage 4: stride multiply / t squared ----------------
  logic signed [57:0] mul_c;
  logic [41:0]        mul_t;
  logic signed [59:0] b_d;
  logic signed [59:0] b_q;

  assign mul_c = a_q * $signed({1'b0, cell_stride_q});
  assign mul_t = a_q[20:0] * a_q[20:0];

  always_comb begin
    case (mode_q[3])
      MODE_CENTER: b_d = 60'(mul_c);
      MODE_SIZE:   b_d = $signed({18'd0, mul_t});
      default:     b_d = 60'(a_q);
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      b_q <= b_d;
    end
  end

  // ---------------- stage 5: anchor multiply ----------------
  logic [57:0]        mul_a;
  logic signed [59:0] c_d;
  logic signed [59:0] c_q;
  logic               pass_q;

  assign mul_a = b_q[41:0] * anchor_q[4];

  always_comb begin
    if (mode_q[4] == MODE_SIZE) begin
      c_d = $signed({2'd0, mul_a});
    end else begin
      c_d = b_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      c_q    <= c_d;
      pass_q <= (mode_q[4] == MODE_PASS);
    end
  end

  // ---------------- stage 6: round half away from zero ----------------
  logic        neg_d;
  logic [59:0] mag;
  logic [59:0] rsum;
  logic [35:0] r_d;
  logic [35:0] r_q;
  logic        neg_q;

  always_comb begin
    neg_d = !pass_q && c_q[59];
    mag   = neg_d ? 60'(-c_q) : 60'(c_q);
    rsum  = mag + (60'd1 << 23);
    r_d   = pass_q ? c_q[35:0] : rsum[59:24];
  end

  always_ff @(posedge clk_i) begin
    if (en[6]) begin
      r_q   <= r_d;
      neg_q <= neg_d;
    end
  end

  // ---------------- stage 7: saturate, output register ----------------
  logic        ovf;
  logic [31:0] dec_d;
  logic [31:0] dec_q;

  always_comb begin
    ovf = |r_q[35:31];
    if (neg_q) begin
      dec_d = ovf ? 32'h8000_0000 : 32'(-r_q[31:0]);
    end else begin
      dec_d = ovf ? 32'h7fff_ffff : r_q[31:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[7]) begin
      dec_q <= dec_d;
    end
  end

  assign out_o.valid              = v_q[NSTG-1];
  assign out_o.data.decoded_value = $signed(dec_q);
  assign out_o.data.attr_echo     = attr_q[NSTG-1];

  // ---------------- assertions ----------------
  a_cfg_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_en && paddr[3:2] == ybd_pkg::REG_CENTER_SCALE)
      |=> center_scale_q == $past(pwdata[15:0]))
    else $error("center_scale write not taken");

  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> v_q[0])
    else $error("accepted beat missing from stage 0");

  a_mid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[3] && !en[3]) |=> v_q[3])
    else $error("stalled beat dropped in stage 3");

  a_pass_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && attr_q[NSTG-1] >= 8'd4) |-> dec_q <= 32'd4096)
    else $error("pass result out of sigmoid range");

  a_size_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && (attr_q[NSTG-1] == 8'd2 || attr_q[NSTG-1] == 8'd3)) |-> !dec_q[31])
    else $error("size result negative");

endmodule

`default_nettype wire

[rtl/ybd_sig_rom.sv]
// ybd_sig_rom: sigmoid lookup ROM with registered, enabled read port.
// Contents are built at elaboration in Q30 integer arithmetic; uses ybd_pkg.
`default_nettype none

module ybd_sig_rom #(
  parameter int unsigned SIGMOID_TABLE_DEPTH = 1024
) (
  input  wire logic                               clk_i,
  input  wire logic                               en_i,
  input  wire logic [$clog2(SIGMOID_TABLE_DEPTH)-1:0] addr_i,
  output logic [ybd_pkg::SIG_W-1:0]               data_o
);

  localparam logic [63:0] Q30_ONE   = 64'd1 << 30;
  localparam logic [63:0] Q30_INV_E = 64'd395007542;

  typedef logic [ybd_pkg::SIG_W-1:0] tab_t [SIGMOID_TABLE_DEPTH];

  // shift-subtract division, elaboration only
  function automatic logic [63:0] long_div(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[63:0], num[i]};
      if (r >= {1'b0, den}) begin
        r    = r - {1'b0, den};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic [63:0] div_term(input logic [63:0] x, input int n);
    logic [63:0] q;
    case (n)
      1:       q = x;
      2:       q = x / 64'd2;
      3:       q = x / 64'd3;
      4:       q = x / 64'd4;
      5:       q = x / 64'd5;
      6:       q = x / 64'd6;
      7:       q = x / 64'd7;
      8:       q = x / 64'd8;
      9:       q = x / 64'd9;
      10:      q = x / 64'd10;
      11:      q = x / 64'd11;
      12:      q = x / 64'd12;
      13:      q = x / 64'd13;
      14:      q = x / 64'd14;
      15:      q = x / 64'd15;
      default: q = x / 64'd16;
    endcase
    return q;
  endfunction

  function automatic logic [ybd_pkg::SIG_W-1:0] sig_point(input logic [63:0] bin);
    logic signed [63:0] mid;
    logic               neg;
    logic [63:0]        mag;
    logic [63:0]        whole;
    logic [63:0]        frac;
    logic [63:0]        term;
    logic [63:0]        sum;
    logic [63:0]        em;
    logic [63:0]        den;
    logic [63:0]        s;
    mid   = $signed(((64'd2 * bin + 64'd1) << 35) / 64'(SIGMOID_TABLE_DEPTH))
            - (64'sd1 <<< 35);
    neg   = mid < 0;
    mag   = neg ? 64'(-mid) : 64'(mid);
    whole = mag >> 30;
    frac  = mag & (Q30_ONE - 64'd1);
    term  = Q30_ONE;
    sum   = term;
    for (int n = 1; n <= 16; n++) begin
      term = div_term((term * frac) >> 30, n);
      sum  = sum + term;
    end
    em = long_div(64'd1 << 60, sum);
    for (int k = 0; k < 64; k++) begin
      if (64'(k) < whole) begin
        em = (em * Q30_INV_E) >> 30;
      end
    end
    den = Q30_ONE + em;
    s   = long_div((64'd1 << 46) + (den >> 1), den);
    if (neg) begin
      s = 64'd65536 - s;
    end
    return s[ybd_pkg::SIG_W-1:0];
  endfunction

  function automatic tab_t build_tab();
    tab_t t;
    for (int k = 0; k < int'(SIGMOID_TABLE_DEPTH); k++) begin
      t[k] = sig_point(64'(k));
    end
    return t;
  endfunction

  localparam tab_t SIG_TAB = build_tab();

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_o <= SIG_TAB[addr_i];
    end
  end

endmodule

`default_nettype wire
